/* hdl/sefr_pkg.sv */
package sefr_pkg;

    // Largest payload length that a frame may announce.
    localparam int unsigned MaxPayload = 255;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned EventW = 2;
    localparam int unsigned OutW   = 24;
    localparam int unsigned UserW  = 3;

    // Configuration register indexes.
    localparam logic CfgStartByte = 1'b0;
    localparam logic CfgEndByte   = 1'b1;

    // Event codes carried with each result item.
    typedef enum logic [EventW-1:0] {
        EV_NONE   = 2'd0,
        EV_READY  = 2'd1,
        EV_CSUM   = 2'd2,
        EV_FORMAT = 2'd3
    } t_event;

    // Receive phase, one-hot.
    typedef enum logic [4:0] {
        PH_HUNT = 5'b00001,
        PH_LEN  = 5'b00010,
        PH_DATA = 5'b00100,
        PH_CSUM = 5'b01000,
        PH_END  = 5'b10000
    } t_phase;

    // One result item.
    typedef struct packed {
        logic [ByteW-1:0] frame_length;
        logic [ByteW-1:0] data_index;
        logic [ByteW-1:0] data_byte;
        logic             data_valid;
        t_event           event_res;
    } t_result;

endpackage

/* hdl/sefr_deframer.sv */
module sefr_deframer
    import sefr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [ByteW-1:0] i_byte,
    input  logic [ByteW-1:0] i_start_byte,
    input  logic [ByteW-1:0] i_end_byte,
    output t_result          o_result
);

    t_phase           r_phase, n_phase;
    logic [ByteW-1:0] r_len, n_len;
    logic [ByteW-1:0] r_pos, n_pos;
    logic [ByteW-1:0] r_xor, n_xor;
    logic [ByteW-1:0] pos_inc;
    t_result          res;

    assign pos_inc = r_pos + 1'b1;

    // Next state and the result item for the byte on the input.
    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_pos   = r_pos;
        n_xor   = r_xor;
        res     = '0;
        res.event_res = EV_NONE;
        case (r_phase)
            PH_HUNT: begin
                if (i_byte == i_start_byte) begin
                    n_phase = PH_LEN;
                    n_len   = '0;
                    n_pos   = '0;
                    n_xor   = '0;
                end
            end
            PH_LEN: begin
                n_len = i_byte;
                n_pos = '0;
                n_xor = '0;
                if ({1'b0, i_byte} > (ByteW+1)'(MaxPayload)) begin
                    n_phase       = PH_HUNT;
                    res.event_res = EV_FORMAT;
                end else if (i_byte == '0) begin
                    n_phase = PH_CSUM;
                end else begin
                    n_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                res.data_valid = 1'b1;
                res.data_byte  = i_byte;
                res.data_index = r_pos;
                n_xor = r_xor ^ i_byte;
                n_pos = pos_inc;
                if (pos_inc >= r_len) begin
                    n_phase = PH_CSUM;
                end
            end
            PH_CSUM: begin
                if (i_byte != r_xor) begin
                    n_phase       = PH_HUNT;
                    res.event_res = EV_CSUM;
                end else begin
                    n_phase = PH_END;
                end
            end
            PH_END: begin
                if (i_byte == i_end_byte) begin
                    n_phase       = PH_HUNT;
                    res.event_res = EV_READY;
                end else begin
                    res.event_res = EV_FORMAT;
                    if (i_byte == i_start_byte) begin
                        // A start byte in place of the end byte opens a new frame.
                        n_phase = PH_LEN;
                        n_len   = '0;
                        n_pos   = '0;
                        n_xor   = '0;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
            end
            default: begin
                n_phase       = PH_HUNT;
                n_len         = '0;
                n_pos         = '0;
                n_xor         = '0;
                res.event_res = EV_FORMAT;
            end
        endcase
        res.frame_length = n_len;
    end

    // State advances only on an accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_len   <= '0;
            r_pos   <= '0;
            r_xor   <= '0;
        end else if (i_valid) begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_pos   <= n_pos;
            r_xor   <= n_xor;
        end
    end

    assign o_result = res;

    // While payload bytes arrive, the position stays below the length.
    a_pos_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA |-> r_pos < r_len)
        else $error("payload position reached the frame length");

    // The last payload byte moves on to the checksum.
    a_data_to_csum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && r_phase == PH_DATA && pos_inc >= r_len |=> r_phase == PH_CSUM)
        else $error("last payload byte did not lead to the checksum");

    // A start byte while hunting opens a frame with a clear checksum.
    a_open_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && r_phase == PH_HUNT && i_byte == i_start_byte
        |=> r_phase == PH_LEN && r_xor == '0 && r_pos == '0)
        else $error("start byte did not open a frame");

    // A frame is reported ready only from the end-byte phase.
    a_ready_from_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && res.event_res == EV_READY |-> r_phase == PH_END)
        else $error("frame ready outside the end-byte phase");

endmodule

/* hdl/stx_etx_frame_receiver.sv */
// STX/ETX frame receiver. Each input item is one received byte; each accepted
// byte yields exactly one registered result item; a new byte can be accepted
// every cycle while the output drains. The deframing state advances as a byte
// is taken, and the result sits in a single output register, so the input
// stalls only while that register is full and not being drained. A frame is
// start byte, length, payload, XOR of the payload, end byte. Payload bytes are
// not buffered: each is passed out with its index, and the frame is committed
// by the consumer on the frame-ready event. Configuration (start and end byte
// values): the user writes it via the write port, only while idle (not enforced).
module stx_etx_frame_receiver
    import sefr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Configuration write port.
    input  logic             i_cfg_we,
    input  logic             i_cfg_addr,
    input  logic [ByteW-1:0] i_cfg_wdata,
    // Input bytes.
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [ByteW-1:0] s_axis_tdata,   // [7:0] byte_in
    // Result items.
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OutW-1:0]  m_axis_tdata,   // [7:0] data_byte, [15:8] data_index,
                                             // [23:16] frame_length
    output logic [UserW-1:0] m_axis_tuser    // [1:0] event_res, [2] data_valid
);

    logic [ByteW-1:0] r_start_byte;
    logic [ByteW-1:0] r_end_byte;
    logic             r_out_valid;
    t_result          r_out;
    t_result          result;
    logic             accept;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= 8'd2;
            r_end_byte   <= 8'd3;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CfgStartByte: r_start_byte <= i_cfg_wdata;
                CfgEndByte:   r_end_byte   <= i_cfg_wdata;
                default:      r_start_byte <= r_start_byte;
            endcase
        end
    end

    // A byte is taken whenever the output register is free or being emptied.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    sefr_deframer u_deframer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (accept),
        .i_byte       (s_axis_tdata),
        .i_start_byte (r_start_byte),
        .i_end_byte   (r_end_byte),
        .o_result     (result)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.frame_length, r_out.data_index, r_out.data_byte};
    assign m_axis_tuser  = {r_out.data_valid, r_out.event_res};

endmodule

/* bench/tb_stx_etx_frame_receiver.sv */
module tb_stx_etx_frame_receiver;
    import sefr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Ways in which a generated frame is spoiled on purpose.
    typedef enum int {
        FLAW_NONE,
        FLAW_CSUM,
        FLAW_END_OTHER,
        FLAW_END_RESTART
    } t_flaw;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic             i_cfg_addr;
    logic [ByteW-1:0] i_cfg_wdata;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [ByteW-1:0] s_axis_tdata;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [OutW-1:0]  m_axis_tdata;
    logic [UserW-1:0] m_axis_tuser;

    // Deframer state as the bench expects it, plus its own copy of the registers.
    t_phase           pred_phase = PH_HUNT;
    logic [ByteW-1:0] pred_len   = '0;
    logic [ByteW-1:0] pred_count = '0;
    logic [ByteW-1:0] pred_xor   = '0;
    logic [ByteW-1:0] stx_val    = 8'h02;
    logic [ByteW-1:0] etx_val    = 8'h03;

    t_result          pending_results[$];
    int               error_count = 0;
    int               sent_bytes  = 0;
    bit               stall_en    = 1'b1;
    bit               frame_open  = 1'b0;

    stx_etx_frame_receiver uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock with a 12 ns period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Advances the expected deframer state by one received byte.
    function automatic t_result deframe_byte(input logic [ByteW-1:0] b);
        t_result r;
        r = '0;
        r.event_res = EV_NONE;
        case (pred_phase)
            PH_HUNT: begin
                if (b == stx_val) begin
                    pred_phase = PH_LEN;
                    pred_len   = '0;
                    pred_count = '0;
                    pred_xor   = '0;
                end
            end
            PH_LEN: begin
                pred_len   = b;
                pred_count = '0;
                pred_xor   = '0;
                if (int'(b) > int'(MaxPayload)) begin
                    pred_phase  = PH_HUNT;
                    r.event_res = EV_FORMAT;
                end else begin
                    pred_phase = (b == 8'd0) ? PH_CSUM : PH_DATA;
                end
            end
            PH_DATA: begin
                r.data_valid = 1'b1;
                r.data_byte  = b;
                r.data_index = pred_count;
                pred_xor     = pred_xor ^ b;
                pred_count   = pred_count + 8'd1;
                if (pred_count >= pred_len) begin
                    pred_phase = PH_CSUM;
                end
            end
            PH_CSUM: begin
                if (b != pred_xor) begin
                    pred_phase  = PH_HUNT;
                    r.event_res = EV_CSUM;
                end else begin
                    pred_phase = PH_END;
                end
            end
            PH_END: begin
                if (b == etx_val) begin
                    pred_phase  = PH_HUNT;
                    r.event_res = EV_READY;
                end else begin
                    if (b == stx_val) begin
                        pred_phase = PH_LEN;
                        pred_len   = '0;
                        pred_count = '0;
                        pred_xor   = '0;
                    end else begin
                        pred_phase = PH_HUNT;
                    end
                    r.event_res = EV_FORMAT;
                end
            end
            default: begin
                pred_phase  = PH_HUNT;
                pred_len    = '0;
                pred_count  = '0;
                pred_xor    = '0;
                r.event_res = EV_FORMAT;
            end
        endcase
        r.frame_length = pred_len;
        return r;
    endfunction

    // Result items are checked first, then the accepted byte is predicted, so an
    // item's expectation is always queued before its result can arrive.
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata, m_axis_tuser};
                if (pending_results.size() == 0) begin
                    $error("unexpected result item: tdata %h tuser %h", m_axis_tdata,
                           m_axis_tuser);
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.event_res != want.event_res) begin
                        $error("event_res: expected %0d, got %0d", want.event_res,
                               got.event_res);
                        error_count++;
                    end
                    if (got.data_valid != want.data_valid) begin
                        $error("data_valid: expected %0d, got %0d", want.data_valid,
                               got.data_valid);
                        error_count++;
                    end
                    if (got.data_byte != want.data_byte) begin
                        $error("data_byte: expected %0d, got %0d", want.data_byte,
                               got.data_byte);
                        error_count++;
                    end
                    if (got.data_index != want.data_index) begin
                        $error("data_index: expected %0d, got %0d", want.data_index,
                               got.data_index);
                        error_count++;
                    end
                    if (got.frame_length != want.frame_length) begin
                        $error("frame_length: expected %0d, got %0d", want.frame_length,
                               got.frame_length);
                        error_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                pending_results.push_back(deframe_byte(s_axis_tdata));
            end
        end
    end

    // Result-side backpressure.
    always @(posedge i_clk) begin
        m_axis_tready <= stall_en ? ($urandom_range(99) >= 35) : 1'b1;
    end

    // Sends one byte, with random gaps before it when idling is on. Valid stays
    // high after the handshake so that back-to-back bytes need no toggle.
    task automatic send_byte(input logic [ByteW-1:0] b);
        if (stall_en) begin
            while ($urandom_range(99) < 35) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        sent_bytes++;
    endtask

    // Stops sending and waits for every outstanding result item.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // Writes both frame delimiters once the block has drained.
    task automatic set_delimiters(input logic [ByteW-1:0] stx, input logic [ByteW-1:0] etx);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CfgStartByte;
        i_cfg_wdata <= stx;
        @(posedge i_clk);
        i_cfg_addr  <= CfgEndByte;
        i_cfg_wdata <= etx;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        stx_val = stx;
        etx_val = etx;
        @(posedge i_clk);
    endtask

    // Sends one frame with random payload, spoiled as the flaw says. After a
    // restart on the end byte the next frame goes out without its start byte.
    task automatic send_frame(input int len, input t_flaw flaw);
        logic [ByteW-1:0] sum;
        logic [ByteW-1:0] b;
        sum = '0;
        if (!frame_open) begin
            send_byte(stx_val);
        end
        frame_open = 1'b0;
        send_byte(len[ByteW-1:0]);
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom_range(255));
            sum ^= b;
            send_byte(b);
        end
        if (flaw == FLAW_CSUM) begin
            send_byte(sum ^ (8'd1 << $urandom_range(7)));
        end else begin
            send_byte(sum);
            case (flaw)
                FLAW_END_OTHER: begin
                    do b = 8'($urandom_range(255)); while (b == etx_val || b == stx_val);
                    send_byte(b);
                end
                FLAW_END_RESTART: begin
                    send_byte(stx_val);
                    frame_open = 1'b1;
                end
                default: send_byte(etx_val);
            endcase
        end
    endtask

    // Reset delimiters: noise, a zero-length frame and a frame of extreme bytes.
    task automatic test_default_delimiters();
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h02);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h03);
        send_byte(8'h02);
        send_byte(8'h02);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'h03);
    endtask

    // Checksum mismatch, a wrong end byte, and a wrong end byte that restarts.
    task automatic test_frame_errors();
        send_byte(8'h02);
        send_byte(8'h01);
        send_byte(8'h55);
        send_byte(8'h54);
        send_byte(8'h02);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h77);
        send_byte(8'h02);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h02);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h03);
    endtask

    // Delimiters at the ends of their range, and start equal to end.
    task automatic test_delimiter_extremes();
        set_delimiters(8'h00, 8'hFF);
        send_byte(8'hFF);
        send_frame(1, FLAW_NONE);
        send_frame(0, FLAW_NONE);
        set_delimiters(8'hFF, 8'h00);
        send_frame(3, FLAW_NONE);
        send_frame(2, FLAW_END_RESTART);
        send_frame(1, FLAW_NONE);
        // With equal delimiters the end-byte test wins and the frame completes.
        set_delimiters(8'h5A, 8'h5A);
        send_frame(2, FLAW_NONE);
        send_frame(0, FLAW_END_OTHER);
    endtask

    // The longest payload a length byte can announce, sent without any idling.
    task automatic test_longest_frame();
        set_delimiters(8'h02, 8'h03);
        stall_en = 1'b0;
        send_frame(255, FLAW_NONE);
        stall_en = 1'b1;
    endtask

    // Mostly well-formed frames with random content, mixed with noise, damaged
    // and cut-off frames, over several delimiter settings.
    task automatic test_random_traffic();
        logic [ByteW-1:0] stx;
        logic [ByteW-1:0] etx;
        int               pick;
        int               len;
        int               goal;
        bit               paused;
        paused = 1'b0;
        for (int phase = 0; phase < 4; phase++) begin
            stx = 8'($urandom_range(255));
            do etx = 8'($urandom_range(255)); while (etx == stx);
            set_delimiters(stx, etx);
            // The first phase runs without any idling on either side.
            stall_en = (phase != 0);
            goal = sent_bytes + 20;
            while (sent_bytes < goal) begin
                // Once, midway through a phase, let every result drain out.
                if (phase == 2 && !paused && sent_bytes >= goal - 10) begin
                    wait_drained();
                    paused = 1'b1;
                end
                pick = $urandom_range(99);
                len  = ($urandom_range(7) == 0) ? $urandom_range(60) : $urandom_range(9);
                if (pick < 12) begin
                    repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
                end else if (pick < 70) begin
                    send_frame(len, FLAW_NONE);
                end else if (pick < 80) begin
                    send_frame(len, FLAW_CSUM);
                end else if (pick < 88) begin
                    send_frame(len, FLAW_END_OTHER);
                end else if (pick < 94) begin
                    send_frame(len, FLAW_END_RESTART);
                end else begin
                    // A start byte followed by one to three random bytes, as a frame cut short.
                    send_byte(stx_val);
                    repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
                    frame_open = 1'b0;
                end
            end
        end
        stall_en = 1'b1;
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= CfgStartByte;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_delimiters();
        test_frame_errors();
        test_delimiter_extremes();
        test_longest_frame();
        test_random_traffic();

        wait_drained();
        repeat (4) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d result items never arrived", pending_results.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("stx_etx_frame_receiver verification clean");
        end else begin
            $display("stx_etx_frame_receiver verification failed");
        end
        $finish;
    end

    // Hard stop in case a handshake hangs.
    initial begin
        #2_000_000;
        $display("stx_etx_frame_receiver verification failed");
        $finish;
    end

endmodule
